### rtl/core/lspg_pkg.sv
// ----------------------------------------------------------------------------
// lspg_pkg
// shared types, constants and tables for the led strip pattern generator
// ----------------------------------------------------------------------------
`default_nettype none
package lspg_pkg;
   localparam int MaxPixels = 64;
   localparam int PixW = 6;
   localparam int CntW = 7;

   localparam logic [2:0] ModeSolid   = 3'd0;
   localparam logic [2:0] ModeRainbow = 3'd1;
   localparam logic [2:0] ModeGrad    = 3'd2;
   localparam logic [2:0] ModeTable   = 3'd3;
   localparam logic [2:0] ModeEq      = 3'd4;

   localparam logic [2:0] RegMode   = 3'd0;
   localparam logic [2:0] RegBright = 3'd1;
   localparam logic [2:0] RegCount  = 3'd2;
   localparam logic [2:0] RegSolid  = 3'd3;
   localparam logic [2:0] RegGStart = 3'd4;
   localparam logic [2:0] RegGEnd   = 3'd5;
   localparam logic [2:0] RegBands  = 3'd6;
   localparam logic [2:0] RegPer    = 3'd7;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   function automatic logic [8:0] sine_q(input logic [4:0] idx);
      logic [8:0] v;
      case (idx)
         5'd0: v = 9'd0;     5'd1: v = 9'd25;    5'd2: v = 9'd50;
         5'd3: v = 9'd74;    5'd4: v = 9'd98;    5'd5: v = 9'd121;
         5'd6: v = 9'd142;   5'd7: v = 9'd162;   5'd8: v = 9'd181;
         5'd9: v = 9'd198;   5'd10: v = 9'd213;  5'd11: v = 9'd226;
         5'd12: v = 9'd237;  5'd13: v = 9'd245;  5'd14: v = 9'd251;
         5'd15: v = 9'd255;  default: v = 9'd256;
      endcase
      return v;
   endfunction

   // floor(c*b/255) without a divider
   function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] b);
      logic [15:0] p;
      logic [16:0] q;
      p = c * b;
      q = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
      return q[15:8];
   endfunction
endpackage
`default_nettype wire

### rtl/core/lspg_divider.sv
// ----------------------------------------------------------------------------
// lspg_divider
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module lspg_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [15:0] dividend,
   input  wire logic [7:0]  divisor,
   output logic             done,
   output logic [15:0]      quotient,
   output logic [7:0]       remainder
);
   import lspg_pkg::*;
   logic [15:0] q_ff, q_in;
   logic [8:0]  r_ff, r_in;
   logic [7:0]  d_ff, d_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [8:0]  trial;
   logic [9:0]  sub;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[7:0], q_ff[15]};
      sub = {1'b0, trial} - {2'b0, d_ff};
      if (go) begin
         q_in = dividend; r_in = '0; d_in = divisor; cnt_in = 5'd16; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!sub[9]) begin
            r_in = sub[8:0];
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff[7:0];
endmodule
`default_nettype wire

### rtl/core/led_strip_pattern_generator_core.sv
// ----------------------------------------------------------------------------
// led_strip_pattern_generator_core
// renders led strip effects one pixel at a time
// ----------------------------------------------------------------------------
// A render transaction emits one pixel at a time through the shared
// divider (hue, gradient or band position); in gradient mode the three
// channels take turns on the divider. Band fitting runs at the start of a
// frame. A write transaction keeps busy high for one cycle; in table mode
// its pixel appears in the cycle after. Results carry rsp_valid for one
// cycle and cannot be held off. busy stays high until the transaction's last
// result.
`default_nettype none
module led_strip_pattern_generator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [5:0]  req_target_pixel,
   input  wire logic [23:0] req_new_color,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data,
   output logic             rsp_valid,
   output logic [5:0]       rsp_pixel_number,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic             rsp_last_pixel
);
   import lspg_pkg::*;

   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StWrite = 4'd1;
   localparam logic [3:0] StFitA  = 4'd2;
   localparam logic [3:0] StFitB  = 4'd3;
   localparam logic [3:0] StPix   = 4'd4;
   localparam logic [3:0] StWait  = 4'd5;
   localparam logic [3:0] StTab   = 4'd6;
   localparam logic [3:0] StEqB   = 4'd7;
   localparam logic [3:0] StEqC   = 4'd8;

   logic [2:0]  mode_ff;
   logic [7:0]  bright_ff;
   logic [6:0]  count_ff;
   logic [23:0] solid_ff, gstart_ff, gend_ff;
   logic [5:0]  bands_ff, per_ff;
   logic [7:0]  phase_ff, phase_in;

   logic [23:0] table_mem [MaxPixels];
   logic [23:0] tab_rd_ff;
   logic [5:0]  tab_addr;
   logic [MaxPixels-1:0] tvalid_ff, tvalid_in;

   logic [3:0]  st_ff, st_in;
   logic [5:0]  pix_ff, pix_in;
   logic [5:0]  widx_ff, widx_in;
   logic [23:0] wcol_ff, wcol_in;
   logic [6:0]  tb_ff, tb_in;
   logic [6:0]  pb_ff, pb_in;
   logic [12:0] used_ff, used_in;
   logic [5:0]  bandk_ff, bandk_in;
   logic [5:0]  pos_ff, pos_in;
   logic [7:0]  lvl_ff, lvl_in;
   logic        ov_ff, ov_in;
   logic        ov_valid;
   logic [6:0]  n;

   logic        dgo;
   logic [15:0] ddend;
   logic [7:0]  ddiv;
   logic        ddone;
   logic [15:0] dq;
   logic [7:0]  dr;

   logic        rv_ff, rv_in, rl_ff, rl_in;
   logic [5:0]  rp_ff, rp_in;
   rgb_type     rc_ff, rc_in;

   lspg_divider u_div (
      .clock(clock), .reset(reset), .go(dgo), .dividend(ddend), .divisor(ddiv),
      .done(ddone), .quotient(dq), .remainder(dr)
   );

   assign n = (count_ff == 7'd0) ? 7'd1 : (count_ff > 7'd64 ? 7'd64 : count_ff);

   // per-pixel color compute from divider results
   rgb_type pc;
   logic [7:0] hh, xx;
   logic [10:0] six;
   logic [2:0]  sec;
   logic [7:0]  rr6;
   logic [15:0] arg16;
   logic [15:0] tsum;
   logic [5:0]  jj;
   logic [8:0]  sv;
   logic [9:0]  uu;
   logic [16:0] lvl_prod;
   logic [7:0]  kk25;
   logic [23:0] tabc;

   function automatic logic [7:0] lerp_ch(input logic [7:0] a, input logic [7:0] b,
                                          input logic [15:0] q);
      logic [7:0] r;
      r = (b >= a) ? a + q[7:0] : a - q[7:0];
      return r;
   endfunction

   always_comb begin
      hh = 8'(phase_ff + dq[7:0]);
      six = 11'(hh) * 11'd6;
      sec = (six >= 11'd1275) ? 3'd5 : (six >= 11'd1020) ? 3'd4 : (six >= 11'd765) ? 3'd3 :
            (six >= 11'd510) ? 3'd2 : (six >= 11'd255) ? 3'd1 : 3'd0;
      rr6 = 8'(six - 11'(sec) * 11'd255);
      if (six == 11'd1530) begin
         sec = 3'd0; rr6 = 8'd0;
      end
      xx = sec[0] ? 8'd255 - rr6 : rr6;
      arg16 = (16'(phase_ff) + 16'(bandk_ff) * 16'd20) * 16'd1043;
      tsum = arg16 + 16'd512;
      jj = tsum[15:10];
      sv = jj[4] ? sine_q(5'd16 - {1'b0, jj[3:0]}) : sine_q({1'b0, jj[3:0]});
      uu = jj[5] ? 10'd256 - 10'(sv) : 10'd256 + 10'(sv);
      lvl_prod = 17'(uu) * 17'(pb_ff - 7'd1);
      kk25 = 8'(bandk_ff) * 8'd25;
      tabc = tvalid_ff[pix_ff] ? tab_rd_ff : 24'd0;
      pc = '0;
      case (mode_ff)
         ModeSolid: pc = '{scale8(solid_ff[23:16], bright_ff),
                           scale8(solid_ff[15:8], bright_ff), scale8(solid_ff[7:0], bright_ff)};
         ModeRainbow: begin
            case (sec)
               3'd0: pc = '{8'd255, xx, 8'd0};
               3'd1: pc = '{xx, 8'd255, 8'd0};
               3'd2: pc = '{8'd0, 8'd255, xx};
               3'd3: pc = '{8'd0, xx, 8'd255};
               3'd4: pc = '{xx, 8'd0, 8'd255};
               default: pc = '{8'd255, 8'd0, xx};
            endcase
            pc = '{scale8(pc.r, bright_ff), scale8(pc.g, bright_ff), scale8(pc.b, bright_ff)};
         end
         ModeTable: pc = '{scale8(tabc[23:16], bright_ff), scale8(tabc[15:8], bright_ff),
                           scale8(tabc[7:0], bright_ff)};
         default: begin
            if (ov_ff && pos_ff <= 6'(lvl_ff))
               pc = '{scale8(kk25, bright_ff), scale8(8'd255 - kk25, bright_ff),
                      scale8(8'd128, bright_ff)};
         end
      endcase
   end

   // gradient: three channels share the divider sequentially via per-pixel passes
   logic [1:0]  gch_ff, gch_in;
   rgb_type     gacc_ff, gacc_in;
   logic [7:0]  ga, gb, gdiff;

   always_comb begin
      case (gch_ff)
         2'd0: begin
            ga = scale8(gstart_ff[23:16], bright_ff); gb = scale8(gend_ff[23:16], bright_ff);
         end
         2'd1: begin
            ga = scale8(gstart_ff[15:8], bright_ff); gb = scale8(gend_ff[15:8], bright_ff);
         end
         default: begin
            ga = scale8(gstart_ff[7:0], bright_ff); gb = scale8(gend_ff[7:0], bright_ff);
         end
      endcase
      gdiff = (gb >= ga) ? gb - ga : ga - gb;
   end

   assign ov_valid = (13'(pix_ff) < used_ff);

   always_comb begin
      st_in = st_ff; pix_in = pix_ff; widx_in = widx_ff; wcol_in = wcol_ff;
      tb_in = tb_ff; pb_in = pb_ff; used_in = used_ff; bandk_in = bandk_ff;
      pos_in = pos_ff; lvl_in = lvl_ff; ov_in = ov_ff; phase_in = phase_ff;
      tvalid_in = tvalid_ff; gch_in = gch_ff; gacc_in = gacc_ff;
      rv_in = 1'b0; rl_in = 1'b0; rp_in = rp_ff; rc_in = rc_ff;
      dgo = 1'b0; ddend = '0; ddiv = 8'd1;
      tab_addr = pix_ff;
      case (st_ff)
         StIdle: begin
            if (start) begin
               if (req_func) begin
                  widx_in = (7'(req_target_pixel) > n - 7'd1) ? 6'(n - 7'd1) : req_target_pixel;
                  wcol_in = req_new_color;
                  st_in = StWrite;
               end else if (mode_ff <= ModeEq) begin
                  pix_in = '0; gch_in = '0;
                  tb_in = 7'(bands_ff); pb_in = 7'(per_ff);
                  used_in = 13'(bands_ff) * 13'(per_ff);
                  st_in = StFitA;
               end
            end
         end
         StWrite: begin
            tvalid_in[widx_ff] = 1'b1;
            if (mode_ff == ModeTable) begin
               rv_in = 1'b1; rl_in = 1'b1; rp_in = widx_ff;
               rc_in = '{scale8(wcol_ff[23:16], bright_ff), scale8(wcol_ff[15:8], bright_ff),
                         scale8(wcol_ff[7:0], bright_ff)};
            end
            st_in = StIdle;
         end
         StFitA: begin
            if (used_ff > 13'(n) || used_ff == 13'd0) begin
               if (tb_ff > n) tb_in = n;
               st_in = StFitB;
               used_in = 13'(n);
            end else
               st_in = StPix;
         end
         StFitB: begin
            if (tb_ff == 7'd0)
               st_in = StEqB;
            else begin
               dgo = 1'b1; ddend = 16'(n); ddiv = 8'(tb_ff);
               st_in = StEqC;
            end
         end
         StEqC: begin
            if (ddone) begin
               pb_in = (dq[6:0] == 7'd0) ? 7'd1 : dq[6:0];
               st_in = StEqB;
            end
         end
         StEqB: begin
            if (tb_ff == 7'd0 && pb_ff == 7'd0) pb_in = 7'd1;
            used_in = 13'(tb_ff) * 13'(pb_ff);
            st_in = StPix;
         end
         StPix: begin
            dgo = 1'b1;
            case (mode_ff)
               ModeRainbow: begin
                  ddend = 16'(pix_ff) << 8; ddiv = 8'(n);
               end
               ModeGrad: begin
                  ddend = (n == 7'd1) ? 16'(gdiff) : 16'(gdiff) * 16'(pix_ff);
                  ddiv = (n == 7'd1) ? 8'd2 : 8'(n - 7'd1);
               end
               ModeEq: begin
                  ddend = 16'(pix_ff); ddiv = 8'(pb_ff);
               end
               default: begin
                  ddend = '0; ddiv = 8'd1;
               end
            endcase
            st_in = StWait;
         end
         StWait: begin
            if (ddone) begin
               if (mode_ff == ModeEq) begin
                  bandk_in = dq[5:0]; pos_in = dr[5:0]; ov_in = ov_valid;
                  st_in = StTab;
               end else if (mode_ff == ModeGrad && gch_ff != 2'd2) begin
                  case (gch_ff)
                     2'd0: gacc_in.r = lerp_ch(ga, gb, dq);
                     default: gacc_in.g = lerp_ch(ga, gb, dq);
                  endcase
                  gch_in = gch_ff + 2'd1;
                  st_in = StPix;
               end else
                  st_in = StTab;
               if (mode_ff == ModeGrad && gch_ff == 2'd2) begin
                  gacc_in.b = lerp_ch(ga, gb, dq);
               end
            end
         end
         default: begin
            // StTab: emit pixel (in equalizer mode, first compute the bar level)
            if (mode_ff == ModeEq && lvl_ff == 8'hff) begin
               lvl_in = lvl_prod[16:9];
            end else begin
               rv_in = 1'b1; rp_in = pix_ff;
               rc_in = (mode_ff == ModeGrad) ? gacc_ff : pc;
               rl_in = (7'(pix_ff) == n - 7'd1);
               lvl_in = 8'hff; gch_in = '0;
               if (7'(pix_ff) == n - 7'd1) begin
                  st_in = StIdle;
                  if (mode_ff == ModeRainbow || mode_ff == ModeEq) phase_in = phase_ff + 8'd1;
               end else begin
                  pix_in = pix_ff + 6'd1;
                  st_in = StPix;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == StWrite) table_mem[widx_ff] <= wcol_ff;
      tab_rd_ff <= table_mem[tab_addr];
   end

   always_ff @(posedge clock) begin
      widx_ff <= widx_in; wcol_ff <= wcol_in; tb_ff <= tb_in; pb_ff <= pb_in;
      used_ff <= used_in; bandk_ff <= bandk_in; pos_ff <= pos_in; ov_ff <= ov_in;
      gacc_ff <= gacc_in; rp_ff <= rp_in; rc_ff <= rc_in; pix_ff <= pix_in;
      if (reset) begin
         st_ff <= StIdle; phase_ff <= '0; tvalid_ff <= '0; rv_ff <= 1'b0; rl_ff <= 1'b0;
         gch_ff <= '0; lvl_ff <= 8'hff;
         mode_ff <= ModeSolid; bright_ff <= 8'd128; count_ff <= 7'd64;
         solid_ff <= 24'hFF0000; gstart_ff <= 24'hFF0000; gend_ff <= 24'h0000FF;
         bands_ff <= 6'd10; per_ff <= 6'd10;
      end else begin
         st_ff <= st_in; phase_ff <= phase_in; tvalid_ff <= tvalid_in; rv_ff <= rv_in;
         rl_ff <= rl_in; gch_ff <= gch_in; lvl_ff <= lvl_in;
         if (csr_we) begin
            case (csr_index)
               RegMode:   mode_ff <= csr_data[2:0];
               RegBright: bright_ff <= csr_data[7:0];
               RegCount:  count_ff <= csr_data[6:0];
               RegSolid:  solid_ff <= csr_data;
               RegGStart: gstart_ff <= csr_data;
               RegGEnd:   gend_ff <= csr_data;
               RegBands:  bands_ff <= csr_data[5:0];
               default:   per_ff <= csr_data[5:0];
            endcase
         end
      end
   end

   assign busy = (st_ff != StIdle);
   assign rsp_valid = rv_ff;
   assign rsp_pixel_number = rp_ff;
   assign rsp_red = rc_ff.r;
   assign rsp_green = rc_ff.g;
   assign rsp_blue = rc_ff.b;
   assign rsp_last_pixel = rl_ff;
endmodule
`default_nettype wire
